[hdl/ple_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine_core.

package ple_pkg;

   localparam int DEF_CAPACITY     = 64;
   localparam int DEF_HANDLE_WIDTH = 32;

   // Fixed port field widths
   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 7;
   localparam int ELEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT    = 3'd0,
      CMD_READ      = 3'd1,
      CMD_OVERWRITE = 3'd2,
      CMD_POP       = 3'd3,
      CMD_SEARCH    = 3'd4,
      CMD_CLEAR     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FIN
   } state_type;

   // What every cell of the chain does in a cycle
   typedef enum logic [2:0] {
      CH_KEEP,
      CH_INSERT,
      CH_WRITE,
      CH_REMOVE,
      CH_ROTATE
   } chain_op_type;

endpackage

[hdl/ple_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the list chain: holds the handle at a fixed position.
// Depends on ple_pkg (chain_op_type).

module ple_cell #(
   parameter int IDX = 0,
   parameter int PW  = 7,
   parameter int CW  = 7,
   parameter int HW  = 32
) (
   input  logic                  clock,
   input  ple_pkg::chain_op_type op,
   input  logic [PW-1:0]         pos,
   input  logic [CW-1:0]         last,
   input  logic [HW-1:0]         handle,
   input  logic [HW-1:0]         left_q,
   input  logic [HW-1:0]         right_q,
   input  logic [HW-1:0]         head_q,
   output logic [HW-1:0]         q
);

   localparam logic [PW-1:0] MY_POS  = PW'(IDX);
   localparam logic [CW-1:0] MY_SLOT = CW'(IDX);

   logic [HW-1:0] data_ff;
   logic [HW-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (op)
         ple_pkg::CH_KEEP: begin
            data_in = data_ff;
         end
         ple_pkg::CH_INSERT: begin
            if (MY_POS > pos) begin
               data_in = left_q;
            end else if (MY_POS == pos) begin
               data_in = handle;
            end
         end
         ple_pkg::CH_WRITE: begin
            if (MY_POS == pos) begin
               data_in = handle;
            end
         end
         ple_pkg::CH_REMOVE: begin
            if (MY_POS >= pos) begin
               data_in = right_q;
            end
         end
         ple_pkg::CH_ROTATE: begin
            // rotate the occupied part left; the head wraps to the last slot
            if (MY_SLOT == last) begin
               data_in = head_q;
            end else if (MY_SLOT < last) begin
               data_in = right_q;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

[hdl/positional_list_engine_core.sv]
`timescale 1ns / 1ps
// Positional list engine top level: command control, result buffering and the cell chain.
// Depends on ple_pkg and ple_cell.
// Results: insert, overwrite, clear, unused codes and out-of-range/full/empty cases load
//   the hold stage at the transfer; read and search after the scan, pop after its removal step.
// Throughput: single-step commands one per cycle while the result channel is not stalled;
//   read, search and pop hold off new commands while the chain rotates every entry past cell 0.
// Reset (synchronous, active high) empties the list and both result stages; cell
//   storage is not reset.

module positional_list_engine_core #(
   parameter int CAPACITY     = ple_pkg::DEF_CAPACITY,
   parameter int HANDLE_WIDTH = ple_pkg::DEF_HANDLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ple_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ple_pkg::INDEX_W-1:0]   req_index,
   input  logic [ple_pkg::ELEM_W-1:0]    req_element,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ple_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ple_pkg::ELEM_W-1:0]    rsp_element_out,
   output logic [ple_pkg::FOUND_W-1:0]   rsp_found_index,
   output logic [ple_pkg::COUNT_W-1:0]   rsp_count
);

   // count width, and widened forms for compares and port truncation
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > ple_pkg::INDEX_W) ? CW : ple_pkg::INDEX_W;
   localparam int SW = (CW > ple_pkg::FOUND_W) ? CW : ple_pkg::FOUND_W;
   localparam int NW = (CW > ple_pkg::COUNT_W) ? CW : ple_pkg::COUNT_W;
   localparam int HW = HANDLE_WIDTH;

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   ple_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      step_ff, step_in;

   // command held for the duration of a scan
   ple_pkg::cmd_type   op_cmd_ff, op_cmd_in;
   logic [PW-1:0]      op_pos_ff, op_pos_in;
   logic [HW-1:0]      op_handle_ff, op_handle_in;
   logic [HW-1:0]      value_ff, value_in;
   logic               hit_ff, hit_in;
   logic [ple_pkg::FOUND_W-1:0] hit_idx_ff, hit_idx_in;

   // result hold stage and output register
   logic                          hold_valid_ff, hold_valid_in;
   ple_pkg::status_type           hold_status_ff;
   logic [ple_pkg::ELEM_W-1:0]    hold_value_ff;
   logic [ple_pkg::FOUND_W-1:0]   hold_found_ff;
   logic [ple_pkg::COUNT_W-1:0]   hold_count_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   ple_pkg::status_type           rsp_status_ff;
   logic [ple_pkg::ELEM_W-1:0]    rsp_value_ff;
   logic [ple_pkg::FOUND_W-1:0]   rsp_found_ff;
   logic [ple_pkg::COUNT_W-1:0]   rsp_count_ff;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic out_free, hold_move, req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hold_move = hold_valid_ff && out_free;
   // a new command needs the hold stage free by the end of this cycle
   assign req_ready = (state_ff == ple_pkg::S_IDLE) && (!hold_valid_ff || hold_move);
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   ple_pkg::cmd_type req_cmd_t;
   logic [HW-1:0]    req_handle;
   logic [PW-1:0]    pos_x, cnt_x, cap_x, step_x;
   logic             ins_ok, acc_ok, list_full, list_empty;
   logic [CW-1:0]    last_w;
   logic             start_scan, scan_end;

   assign req_cmd_t  = ple_pkg::cmd_type'(req_cmd);
   assign req_handle = HW'(req_element);
   assign pos_x      = PW'(req_index);
   assign cnt_x      = PW'(count_ff);
   assign cap_x      = PW'(CAPACITY);
   assign step_x     = PW'(step_ff);
   assign ins_ok     = pos_x <= cnt_x;
   assign acc_ok     = pos_x < cnt_x;
   assign list_full  = cnt_x == cap_x;
   assign list_empty = count_ff == '0;
   assign last_w     = count_ff - CW'(1);
   assign scan_end   = step_ff == last_w;

   // read and pop in range, and search of a non-empty list, walk the chain
   assign start_scan = req_fire &&
                       ((((req_cmd_t == ple_pkg::CMD_READ) || (req_cmd_t == ple_pkg::CMD_POP))
                         && acc_ok) ||
                        ((req_cmd_t == ple_pkg::CMD_SEARCH) && !list_empty));

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   ple_pkg::chain_op_type chain_op;
   logic [PW-1:0]         chain_pos;
   logic [HW-1:0]         chain_handle;
   logic [HW-1:0]         cell_q [CAPACITY];
   logic [HW-1:0]         head_q;

   assign head_q = cell_q[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [HW-1:0] left_q, right_q;
      if (i == 0) begin : g_first
         assign left_q = chain_handle;
      end else begin : g_inner_left
         assign left_q = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_q = cell_q[i];
      end else begin : g_inner_right
         assign right_q = cell_q[i+1];
      end

      ple_cell #(
         .IDX (i),
         .PW  (PW),
         .CW  (CW),
         .HW  (HW)
      ) u_cell (
         .clock   (clock),
         .op      (chain_op),
         .pos     (chain_pos),
         .last    (last_w),
         .handle  (chain_handle),
         .left_q  (left_q),
         .right_q (right_q),
         .head_q  (head_q),
         .q       (cell_q[i])
      );
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ple_pkg::S_IDLE: begin
            if (start_scan) begin
               state_in = ple_pkg::S_SCAN;
            end
         end
         ple_pkg::S_SCAN: begin
            if (scan_end) begin
               state_in = (op_cmd_ff == ple_pkg::CMD_POP) ? ple_pkg::S_FIN : ple_pkg::S_IDLE;
            end
         end
         ple_pkg::S_FIN: begin
            state_in = ple_pkg::S_IDLE;
         end
         default: begin
            state_in = ple_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath control and result formation
   // ---------------------------------------------------------------------
   logic                        res_load;
   ple_pkg::status_type         res_status;
   logic [HW-1:0]               res_value;
   logic [ple_pkg::FOUND_W-1:0] res_found;
   logic [SW-1:0]               step_wide;
   logic [NW-1:0]               count_wide;
   logic                        cap_now, hit_now;
   logic [HW-1:0]               value_sel;

   assign step_wide  = SW'(step_ff);
   assign count_wide = NW'(count_in);
   // head holds original entry step_ff during a scan
   assign cap_now    = step_x == op_pos_ff;
   assign hit_now    = (head_q == op_handle_ff) && !hit_ff;
   assign value_sel  = cap_now ? head_q : value_ff;

   always_comb begin
      chain_op     = ple_pkg::CH_KEEP;
      chain_pos    = pos_x;
      chain_handle = req_handle;
      count_in     = count_ff;
      step_in      = step_ff;
      op_cmd_in    = op_cmd_ff;
      op_pos_in    = op_pos_ff;
      op_handle_in = op_handle_ff;
      value_in     = value_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      res_load     = 1'b0;
      res_status   = ple_pkg::ST_OK;
      res_value    = '0;
      res_found    = '0;

      unique case (state_ff)
         ple_pkg::S_IDLE: begin
            if (req_fire) begin
               op_cmd_in    = req_cmd_t;
               op_pos_in    = pos_x;
               op_handle_in = req_handle;
               step_in      = '0;
               hit_in       = 1'b0;
               hit_idx_in   = '0;
               value_in     = '0;
               res_load     = !start_scan;
               unique case (req_cmd_t)
                  ple_pkg::CMD_INSERT: begin
                     if (!ins_ok) begin
                        res_status = ple_pkg::ST_RANGE;
                     end else if (list_full) begin
                        res_status = ple_pkg::ST_FULL;
                     end else begin
                        chain_op = ple_pkg::CH_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ple_pkg::CMD_OVERWRITE: begin
                     if (!acc_ok) begin
                        res_status = ple_pkg::ST_RANGE;
                     end else begin
                        chain_op = ple_pkg::CH_WRITE;
                     end
                  end
                  ple_pkg::CMD_READ, ple_pkg::CMD_POP: begin
                     if (!acc_ok) begin
                        res_status = ple_pkg::ST_RANGE;
                     end
                  end
                  ple_pkg::CMD_SEARCH: begin
                     if (list_empty) begin
                        res_status = ple_pkg::ST_MISS;
                     end
                  end
                  ple_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     res_status = ple_pkg::ST_OK;
                  end
               endcase
            end
         end

         ple_pkg::S_SCAN: begin
            chain_op = ple_pkg::CH_ROTATE;
            step_in  = step_ff + CW'(1);
            value_in = value_sel;
            if (hit_now) begin
               hit_in     = 1'b1;
               hit_idx_in = step_wide[ple_pkg::FOUND_W-1:0];
            end
            if (scan_end && (op_cmd_ff != ple_pkg::CMD_POP)) begin
               res_load = 1'b1;
               if (op_cmd_ff == ple_pkg::CMD_SEARCH) begin
                  res_status = (hit_ff || hit_now) ? ple_pkg::ST_OK : ple_pkg::ST_MISS;
                  res_found  = hit_ff ? hit_idx_ff :
                               (hit_now ? step_wide[ple_pkg::FOUND_W-1:0] : '0);
               end else begin
                  res_value = value_sel;
               end
            end
         end

         ple_pkg::S_FIN: begin
            // list restored by the full rotation; now close the gap
            chain_op  = ple_pkg::CH_REMOVE;
            chain_pos = op_pos_ff;
            count_in  = count_ff - CW'(1);
            res_load  = 1'b1;
            res_value = value_ff;
         end

         default: begin
            chain_op = ple_pkg::CH_KEEP;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   assign hold_valid_in = res_load || (hold_valid_ff && !hold_move);
   assign rsp_valid_in  = hold_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ple_pkg::S_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         hit_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         hit_ff        <= hit_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_cmd_ff    <= op_cmd_in;
      op_pos_ff    <= op_pos_in;
      op_handle_ff <= op_handle_in;
      value_ff     <= value_in;
      hit_idx_ff   <= hit_idx_in;
      if (res_load) begin
         hold_status_ff <= res_status;
         hold_value_ff  <= ple_pkg::ELEM_W'(res_value);
         hold_found_ff  <= res_found;
         hold_count_ff  <= count_wide[ple_pkg::COUNT_W-1:0];
      end
      if (hold_move) begin
         rsp_status_ff <= hold_status_ff;
         rsp_value_ff  <= hold_value_ff;
         rsp_found_ff  <= hold_found_ff;
         rsp_count_ff  <= hold_count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element_out = rsp_value_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_count       = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      PW'(count_ff) <= cap_x)
      else $error("entry count above capacity");

   a_scan_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::S_SCAN) |-> (!list_empty && (step_ff < count_ff)))
      else $error("scan step outside occupied cells");

   a_scan_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::S_SCAN) |=> $stable(count_ff))
      else $error("entry count changed during scan");

   a_fin_after_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::S_FIN) |->
         ((op_cmd_ff == ple_pkg::CMD_POP) && ($past(state_ff) == ple_pkg::S_SCAN)))
      else $error("removal step without pop scan");

   a_hold_kept: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !hold_move) |=> (hold_valid_ff && (!res_load || hold_move)))
      else $error("pending result dropped or overwritten");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for positional_list_engine_core: a directed command table, then
// random list traffic, each result checked against a behavioral list model or a fixed row.
// Depends on ple_pkg and the positional_list_engine_core RTL.

module tb_top;

   localparam int CAPACITY       = ple_pkg::DEF_CAPACITY;
   localparam int PHASE_ITEMS    = 140;     // random commands per fill target
   localparam int WATCHDOG_LIMIT = 3000;    // cycles without any transfer
   localparam int DRAIN_CYCLES   = 80;      // wait for stray results after the last expected one
   localparam int MAX_REPORTS    = 10;

   // Command codes the block does not define; it must answer them as no-ops.
   localparam logic [ple_pkg::CMD_W-1:0] CMD_UNUSED6 = 3'd6;
   localparam logic [ple_pkg::CMD_W-1:0] CMD_UNUSED7 = 3'd7;

   typedef struct packed {
      ple_pkg::status_type              status;
      logic [ple_pkg::ELEM_W-1:0]       element_out;
      logic [ple_pkg::FOUND_W-1:0]      found_index;
      logic [ple_pkg::COUNT_W-1:0]      count;
   } list_result_type;

   typedef struct packed {
      logic [ple_pkg::CMD_W-1:0]        cmd;
      logic [ple_pkg::INDEX_W-1:0]      index;
      logic [ple_pkg::ELEM_W-1:0]       element;
      logic                             typed;     // result below is fixed, not predicted
      list_result_type                  result;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [ple_pkg::CMD_W-1:0]      req_cmd;
   logic [ple_pkg::INDEX_W-1:0]    req_index;
   logic [ple_pkg::ELEM_W-1:0]     req_element;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [ple_pkg::STATUS_W-1:0]   rsp_status;
   logic [ple_pkg::ELEM_W-1:0]     rsp_element_out;
   logic [ple_pkg::FOUND_W-1:0]    rsp_found_index;
   logic [ple_pkg::COUNT_W-1:0]    rsp_count;

   positional_list_engine_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_index       (req_index),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_element_out (rsp_element_out),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

   // ---------------------------------------------------------------------
   // List model: shadow copy of the cells and the entry count. Updated once
   // per accepted command transfer, in acceptance order.
   // ---------------------------------------------------------------------
   logic [ple_pkg::ELEM_W-1:0] shadow_cells [0:CAPACITY-1];
   int                         shadow_len;
   list_result_type            pending_results [$];

   int  fail_count;
   int  commands_sent;
   int  results_checked;
   int  peak_len;
   int  full_rejects;
   int  search_hits;
   int  idle_cycles;
   bit  sender_burst;
   bit  receiver_burst;

   function automatic list_result_type apply_list_command(
         logic [ple_pkg::CMD_W-1:0] cmd,
         logic [ple_pkg::INDEX_W-1:0] index,
         logic [ple_pkg::ELEM_W-1:0] element);
      list_result_type res;
      int              pos;
      pos = int'(index);
      res = '0;
      res.status = ple_pkg::ST_OK;
      case (cmd)
         ple_pkg::CMD_INSERT: begin
            // range test first, then the capacity test
            if (pos > shadow_len) begin
               res.status = ple_pkg::ST_RANGE;
            end else if (shadow_len >= CAPACITY) begin
               res.status = ple_pkg::ST_FULL;
               full_rejects++;
            end else begin
               for (int i = shadow_len; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[pos] = element;
               shadow_len++;
            end
         end
         ple_pkg::CMD_READ: begin
            if (pos >= shadow_len) res.status = ple_pkg::ST_RANGE;
            else res.element_out = shadow_cells[pos];
         end
         ple_pkg::CMD_OVERWRITE: begin
            if (pos >= shadow_len) res.status = ple_pkg::ST_RANGE;
            else shadow_cells[pos] = element;
         end
         ple_pkg::CMD_POP: begin
            if (pos >= shadow_len) begin
               res.status = ple_pkg::ST_RANGE;
            end else begin
               res.element_out = shadow_cells[pos];
               for (int i = pos; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_len--;
            end
         end
         ple_pkg::CMD_SEARCH: begin
            // first (lowest) matching position wins
            res.status = ple_pkg::ST_MISS;
            for (int i = 0; i < shadow_len; i++) begin
               if (shadow_cells[i] == element) begin
                  res.status      = ple_pkg::ST_OK;
                  res.found_index = ple_pkg::FOUND_W'(i);
                  search_hits++;
                  break;
               end
            end
         end
         ple_pkg::CMD_CLEAR: begin
            shadow_len = 0;
         end
         default: begin
            // unused codes: plain status ok with the current count
         end
      endcase
      if (shadow_len > peak_len) peak_len = shadow_len;
      res.count = ple_pkg::COUNT_W'(shadow_len);
      return res;
   endfunction

   task automatic note_failure(string what, list_result_type want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("[%0t] %s: want st=%0d el=%h fi=%0d cnt=%0d, got st=%0d el=%h fi=%0d cnt=%0d",
                  $time, what, want.status, want.element_out, want.found_index, want.count,
                  rsp_status, rsp_element_out, rsp_found_index, rsp_count);
   endtask

   // Drive one command at the falling edge after a random gap, hold it until
   // the transfer, then record its expected result.
   task automatic send_command(logic [ple_pkg::CMD_W-1:0] cmd,
                               logic [ple_pkg::INDEX_W-1:0] index,
                               logic [ple_pkg::ELEM_W-1:0] element, logic typed,
                               list_result_type typed_result);
      list_result_type predicted;
      int              gap;
      if ($urandom_range(0, 49) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_cmd     = cmd;
      req_index   = index;
      req_element = element;
      do @(posedge clock); while (!req_ready);
      predicted = apply_list_command(cmd, index, element);
      pending_results.push_back(typed ? typed_result : predicted);
      commands_sent++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Directed table: empty-list accesses, range and no-op codes, handle
   // extremes. Rows with typed=1 carry a result fixed by hand.
   // ---------------------------------------------------------------------
   localparam int DIRECTED_ROWS = 24;
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // access to an empty list
      '{ple_pkg::CMD_READ,      7'd0,   32'h0000_0000, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd0}},
      '{ple_pkg::CMD_POP,       7'd0,   32'h0000_0000, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd0}},
      '{ple_pkg::CMD_OVERWRITE, 7'd0,   32'hFFFF_FFFF, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd0}},
      '{ple_pkg::CMD_SEARCH,    7'd0,   32'h0000_0000, 1'b1,
        '{ple_pkg::ST_MISS,  32'h0, 6'd0, 7'd0}},
      // insert past the end
      '{ple_pkg::CMD_INSERT,    7'd1,   32'h1234_5678, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd0}},
      '{ple_pkg::CMD_INSERT,    7'd127, 32'hFFFF_FFFF, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd0}},
      '{ple_pkg::CMD_CLEAR,     7'd0,   32'h0000_0000, 1'b1,
        '{ple_pkg::ST_OK,    32'h0, 6'd0, 7'd0}},
      // handle extremes
      '{ple_pkg::CMD_INSERT,    7'd0,   32'hFFFF_FFFF, 1'b1,
        '{ple_pkg::ST_OK,    32'h0, 6'd0, 7'd1}},
      '{ple_pkg::CMD_INSERT,    7'd1,   32'h0000_0000, 1'b1,
        '{ple_pkg::ST_OK,    32'h0, 6'd0, 7'd2}},
      '{ple_pkg::CMD_INSERT,    7'd1,   32'hA5A5_5A5A, 1'b0, '0},
      '{ple_pkg::CMD_READ,      7'd0,   32'h0000_0000, 1'b0, '0},
      '{ple_pkg::CMD_READ,      7'd2,   32'hFFFF_FFFF, 1'b0, '0},
      '{ple_pkg::CMD_READ,      7'd3,   32'h0000_0000, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd3}},
      '{ple_pkg::CMD_SEARCH,    7'd0,   32'h0000_0000, 1'b0, '0},
      '{ple_pkg::CMD_SEARCH,    7'd0,   32'h1234_5678, 1'b1,
        '{ple_pkg::ST_MISS,  32'h0, 6'd0, 7'd3}},
      '{ple_pkg::CMD_OVERWRITE, 7'd2,   32'h8000_0001, 1'b0, '0},
      '{ple_pkg::CMD_OVERWRITE, 7'd127, 32'h0000_0000, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd3}},
      '{ple_pkg::CMD_POP,       7'd1,   32'h0000_0000, 1'b0, '0},
      '{ple_pkg::CMD_POP,       7'd0,   32'h0000_0000, 1'b0, '0},
      // unused codes leave the list alone
      '{CMD_UNUSED6,            7'd0,   32'h0000_0000, 1'b1,
        '{ple_pkg::ST_OK,    32'h0, 6'd0, 7'd1}},
      '{CMD_UNUSED7,            7'd127, 32'hFFFF_FFFF, 1'b1,
        '{ple_pkg::ST_OK,    32'h0, 6'd0, 7'd1}},
      '{ple_pkg::CMD_INSERT,    7'd0,   32'h7FFF_FFFF, 1'b0, '0},
      '{ple_pkg::CMD_CLEAR,     7'd64,  32'hFFFF_FFFF, 1'b1,
        '{ple_pkg::ST_OK,    32'h0, 6'd0, 7'd0}},
      '{ple_pkg::CMD_POP,       7'd64,  32'h0000_0000, 1'b1,
        '{ple_pkg::ST_RANGE, 32'h0, 6'd0, 7'd0}}
   };

   // Fill levels the random part steers toward, one per phase. Reaching
   // CAPACITY several times exercises the full-list reject path.
   localparam int PHASES = 8;
   int fill_targets [PHASES] = '{CAPACITY, 0, 20, CAPACITY, 4, 40, CAPACITY, 0};

   // ---------------------------------------------------------------------
   // Command side
   // ---------------------------------------------------------------------
   initial begin
      logic [ple_pkg::CMD_W-1:0]   cmd;
      logic [ple_pkg::INDEX_W-1:0] index;
      logic [ple_pkg::ELEM_W-1:0]  element;
      int                          target;
      int                          roll;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = '0;
      req_index   = '0;
      req_element = '0;
      shadow_len  = 0;
      fail_count  = 0;
      commands_sent   = 0;
      results_checked = 0;
      peak_len     = 0;
      full_rejects = 0;
      search_hits  = 0;
      sender_burst = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r])
         send_command(directed_rows[r].cmd, directed_rows[r].index, directed_rows[r].element,
                      directed_rows[r].typed, directed_rows[r].result);

      // Random part: each phase biases the mix toward its fill level, with
      // a share of out-of-range positions and repeated handles for searches.
      for (int n = 0; n < PHASES * PHASE_ITEMS; n++) begin
         target = fill_targets[n / PHASE_ITEMS];
         roll   = $urandom_range(0, 99);
         if (shadow_len < target && roll < 70) begin
            cmd = ple_pkg::CMD_INSERT;
         end else if (shadow_len > target && roll < 45) begin
            cmd = ple_pkg::CMD_POP;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 22)      cmd = ple_pkg::CMD_INSERT;
            else if (roll < 40) cmd = ple_pkg::CMD_READ;
            else if (roll < 55) cmd = ple_pkg::CMD_OVERWRITE;
            else if (roll < 68) cmd = ple_pkg::CMD_POP;
            else if (roll < 92) cmd = ple_pkg::CMD_SEARCH;
            else if (roll < 96)
               cmd = (target == CAPACITY) ? ple_pkg::CMD_SEARCH : ple_pkg::CMD_CLEAR;
            else if (roll < 98) cmd = CMD_UNUSED6;
            else                cmd = CMD_UNUSED7;
         end

         roll = $urandom_range(0, 99);
         if (roll < 12)
            index = ple_pkg::INDEX_W'($urandom_range(0, 127));
         else if (cmd == ple_pkg::CMD_INSERT)
            index = ple_pkg::INDEX_W'($urandom_range(0, shadow_len));
         else if (shadow_len > 0)
            index = ple_pkg::INDEX_W'($urandom_range(0, shadow_len - 1));
         else
            index = '0;

         // reuse stored handles so searches hit and duplicates appear
         roll = $urandom_range(0, 99);
         if (roll < 35 && shadow_len > 0)
            element = shadow_cells[$urandom_range(0, shadow_len - 1)];
         else if (roll < 45)
            element = ple_pkg::ELEM_W'($urandom_range(0, 3));
         else
            element = $urandom;

         send_command(cmd, index, element, 1'b0, '0);
      end
      req_valid = 1'b0;

      // drain: everything expected has arrived, then watch for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands (%0d from the table), checked %0d results.",
               commands_sent, DIRECTED_ROWS, results_checked);
      $display("Peak list length %0d, full-list rejects %0d, search hits %0d, failures %0d.",
               peak_len, full_rejects, search_hits, fail_count);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random stalls per transfer, with zero-stall stretches.
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ready      = 1'b0;
      receiver_burst = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) receiver_burst = !receiver_burst;
         stall = receiver_burst ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Result checker: every transfer is matched against the oldest expectation.
   always @(posedge clock) begin : p_check
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_failure("result with nothing pending", '0);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_status !== want.status || rsp_element_out !== want.element_out ||
                rsp_found_index !== want.found_index || rsp_count !== want.count)
               note_failure("result mismatch", want);
         end
      end
   end

   // Watchdog: a hang shows up as a long run of cycles with no transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", pending_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
